// ----- hdl/dfu_download_control_engine_top_macros.svh -----
// Assertion helpers for the download control engine checker.
`ifndef DFU_DOWNLOAD_CONTROL_ENGINE_TOP_MACROS_SVH
`define DFU_DOWNLOAD_CONTROL_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DFU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfu check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DFU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("dfu check failed");

`endif

// ----- hdl/dfu_pkg.sv -----
package dfu_pkg;

	// Address space of the download memory
	localparam int ADDR_BITS = 24;

	// Field widths
	localparam int MEM_W   = 25;
	localparam int BLK_W   = 16;
	localparam int LEN_W   = 16;
	localparam int CMD_W   = 8;
	localparam int CADDR_W = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	// Width that holds both the memory size and the address-space cap
	localparam int CAP_W = (ADDR_BITS + 1 > MEM_W) ? ADDR_BITS + 1 : MEM_W;

	// Block-zero commands
	localparam logic [CMD_W-1:0] CMD_ERASE       = 8'h41;
	localparam logic [CMD_W-1:0] CMD_SET_ADDRESS = 8'h21;
	localparam logic [LEN_W-1:0] SET_ADDR_LEN    = 16'd5;

	// Register reset values
	localparam logic [MEM_W-1:0]   MEM_SIZE_RST    = 25'd131072;
	localparam logic [CADDR_W-1:0] ADDR_OFFSET_RST = 32'h0000_1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEM_SIZE    = 1'd0,
		CFG_ADDR_OFFSET = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ACT_DOWNLOAD   = 3'd0,
		ACT_GET_STATUS = 3'd1,
		ACT_GET_STATE  = 3'd2,
		ACT_CLR_STATUS = 3'd3,
		ACT_ABORT      = 3'd4,
		ACT_SET_IF     = 3'd5,
		ACT_GET_IF     = 3'd6
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DN_BUSY  = 3'd1,
		ST_DN_IDLE  = 3'd2,
		ST_MAN_SYNC = 3'd3,
		ST_MANIFEST = 3'd4,
		ST_ERROR    = 3'd5
	} dfu_state_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_WRITE   = 2'd1,
		STS_ADDRESS = 2'd2
	} dfu_status_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [BLK_W-1:0]   block_number;
		logic [LEN_W-1:0]   data_length;
		logic [CMD_W-1:0]   cmd_byte;
		logic [CADDR_W-1:0] cmd_address;
		logic               mem_locked;
	} req_t;

	typedef struct packed {
		logic             ack;
		logic [1:0]       status_code;
		logic [2:0]       state_code;
		logic             target_out;
		logic             write_enable;
		logic [MEM_W-1:0] write_offset;
		logic [LEN_W-1:0] write_length;
		logic             transfer_done;
		logic [MEM_W-1:0] file_size;
		logic             to_flash;
		logic             start_program;
	} rsp_t;

	// Configuration write beat
	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]     data;
	} cfg_wr_t;

endpackage

// ----- hdl/dfu_download_control_engine_top.sv -----
// A request beat is captured in the input register, then moves into the result register
// once that register is empty or its beat leaves.
// Throughput: one request per cycle while the output is not stalled; the input register and
// the result register form a two-entry path, so a new request is taken while a result waits.
// Reset (arst_n low, asynchronous): engine state idle/ok, pointers and target cleared,
// mem_size back to 131072 and addr_offset to 4096, both channels empty.
module dfu_download_control_engine_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  dfu_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output dfu_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dfu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dfu_pkg::CFG_W-1:0]     cfg_data
);

	logic             fire;
	logic             valid_s1;
	dfu_pkg::req_t    req_s1;
	dfu_pkg::rsp_t    rsp_d;
	dfu_pkg::cfg_wr_t cfg_wr;

	// Registers take a write beat every cycle
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	dfu_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.fire      (fire),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1)
	);

	dfu_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_wr (cfg_wr),
		.fire   (fire),
		.req_s1 (req_s1),
		.rsp_d  (rsp_d)
	);

	dfu_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.rsp_d     (rsp_d),
		.fire      (fire),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- hdl/dfu_in_stage.sv -----
module dfu_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dfu_pkg::req_t req,
	input  logic          fire,
	output logic          valid_s1,
	output dfu_pkg::req_t req_s1
);

	logic accept;

	// Take a new beat when the stage is empty or the held one moves on this cycle
	assign req_stall = valid_s1 && !fire;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	// Capture payload on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

endmodule

// ----- hdl/dfu_engine.sv -----
module dfu_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  dfu_pkg::cfg_wr_t cfg_wr,
	input  logic             fire,
	input  dfu_pkg::req_t    req_s1,
	output dfu_pkg::rsp_t    rsp_d
);

	// Configuration registers
	logic [dfu_pkg::MEM_W-1:0]   mem_size_q;
	logic [dfu_pkg::CADDR_W-1:0] addr_offset_q;

	// Engine state
	logic [dfu_pkg::MEM_W-1:0] wp_q, wp_d;
	logic [dfu_pkg::MEM_W-1:0] hw_q, hw_d;
	logic [dfu_pkg::BLK_W-1:0] last_blk_q, last_blk_d;
	dfu_pkg::dfu_state_t       state_q, state_d;
	dfu_pkg::dfu_status_t      status_q, status_d;
	logic                      target_q, target_d;

	// Shared decode
	logic [dfu_pkg::CAP_W-1:0]   cap;
	logic [dfu_pkg::MEM_W-1:0]   size;
	logic [dfu_pkg::MEM_W:0]     end_sum;
	logic [dfu_pkg::CADDR_W-1:0] set_addr;
	logic                        is_dn, blk_nz, len_nz, seq_ok, dn_accept;
	logic                        fits, write_ok, addr_ok, abort_done, start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q    <= dfu_pkg::MEM_SIZE_RST;
			addr_offset_q <= dfu_pkg::ADDR_OFFSET_RST;
		end else if (cfg_wr.valid) begin
			unique case (dfu_pkg::cfg_reg_t'(cfg_wr.index))
				dfu_pkg::CFG_MEM_SIZE:    mem_size_q    <= cfg_wr.data[dfu_pkg::MEM_W-1:0];
				dfu_pkg::CFG_ADDR_OFFSET: addr_offset_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// Clamp memory size to the address space
	assign cap  = dfu_pkg::CAP_W'(1) << dfu_pkg::ADDR_BITS;
	assign size = (dfu_pkg::CAP_W'(mem_size_q) > cap) ? cap[dfu_pkg::MEM_W-1:0] : mem_size_q;

	assign is_dn     = (dfu_pkg::action_t'(req_s1.action) == dfu_pkg::ACT_DOWNLOAD);
	assign blk_nz    = (req_s1.block_number != '0);
	assign len_nz    = (req_s1.data_length != '0);
	assign seq_ok    = (state_q == dfu_pkg::ST_DN_IDLE)
			&& ((last_blk_q + dfu_pkg::BLK_W'(1)) == req_s1.block_number);
	assign dn_accept = is_dn && blk_nz && ((state_q == dfu_pkg::ST_IDLE) || seq_ok);
	assign end_sum   = {1'b0, wp_q} + (dfu_pkg::MEM_W+1)'(req_s1.data_length);
	assign fits      = (end_sum <= {1'b0, size});
	assign write_ok  = dn_accept && len_nz && fits && !req_s1.mem_locked;
	assign set_addr  = req_s1.cmd_address - addr_offset_q;
	assign addr_ok   = (set_addr < dfu_pkg::CADDR_W'(size));
	assign abort_done = (dfu_pkg::action_t'(req_s1.action) == dfu_pkg::ACT_ABORT)
			&& (hw_q != '0) && !req_s1.mem_locked;
	assign start     = (dfu_pkg::action_t'(req_s1.action) == dfu_pkg::ACT_GET_STATUS)
			&& (state_q == dfu_pkg::ST_MAN_SYNC);

	// Next state
	always_comb begin
		wp_d       = wp_q;
		hw_d       = hw_q;
		last_blk_d = last_blk_q;
		state_d    = state_q;
		status_d   = status_q;
		target_d   = target_q;
		unique case (dfu_pkg::action_t'(req_s1.action)) inside
			dfu_pkg::ACT_DOWNLOAD: begin
				if (blk_nz) begin
					if (dn_accept) begin
						last_blk_d = req_s1.block_number;
						state_d    = dfu_pkg::ST_DN_IDLE;
						if (!len_nz) begin
							state_d = dfu_pkg::ST_MAN_SYNC;
						end else if (fits) begin
							if (!req_s1.mem_locked) begin
								wp_d = end_sum[dfu_pkg::MEM_W-1:0];
								if (end_sum[dfu_pkg::MEM_W-1:0] > hw_q) begin
									hw_d = end_sum[dfu_pkg::MEM_W-1:0];
								end
							end else begin
								state_d  = dfu_pkg::ST_ERROR;
								status_d = dfu_pkg::STS_WRITE;
							end
						end else begin
							state_d  = dfu_pkg::ST_ERROR;
							status_d = dfu_pkg::STS_ADDRESS;
						end
					end
				end else if (len_nz) begin
					if (req_s1.cmd_byte == dfu_pkg::CMD_ERASE) begin
						state_d = dfu_pkg::ST_DN_BUSY;
					end else if (req_s1.cmd_byte == dfu_pkg::CMD_SET_ADDRESS
							&& req_s1.data_length == dfu_pkg::SET_ADDR_LEN) begin
						if (addr_ok) begin
							wp_d    = set_addr[dfu_pkg::MEM_W-1:0];
							state_d = dfu_pkg::ST_DN_BUSY;
						end else begin
							state_d  = dfu_pkg::ST_ERROR;
							status_d = dfu_pkg::STS_ADDRESS;
						end
					end
				end
			end
			dfu_pkg::ACT_GET_STATUS: begin
				if (state_q == dfu_pkg::ST_DN_BUSY) begin
					state_d = dfu_pkg::ST_IDLE;
				end else if (state_q == dfu_pkg::ST_MAN_SYNC) begin
					state_d = dfu_pkg::ST_MANIFEST;
				end
			end
			dfu_pkg::ACT_CLR_STATUS, dfu_pkg::ACT_ABORT: begin
				wp_d       = '0;
				hw_d       = '0;
				last_blk_d = '0;
				state_d    = dfu_pkg::ST_IDLE;
				status_d   = dfu_pkg::STS_OK;
			end
			dfu_pkg::ACT_SET_IF: begin
				if (req_s1.block_number[dfu_pkg::BLK_W-1:1] == '0) begin
					target_d = req_s1.block_number[0];
				end
			end
			default: ;
		endcase
	end

	// Result fields
	always_comb begin
		rsp_d = '0;
		rsp_d.status_code   = status_q;
		rsp_d.state_code    = state_q;
		rsp_d.target_out    = target_d;
		rsp_d.write_enable  = write_ok;
		rsp_d.write_offset  = write_ok ? wp_q : '0;
		rsp_d.write_length  = write_ok ? req_s1.data_length : '0;
		rsp_d.transfer_done = abort_done;
		rsp_d.file_size     = abort_done ? hw_q : '0;
		rsp_d.to_flash      = abort_done && target_q;
		rsp_d.start_program = start;
		unique case (dfu_pkg::action_t'(req_s1.action)) inside
			dfu_pkg::ACT_SET_IF: rsp_d.ack = (req_s1.block_number[dfu_pkg::BLK_W-1:1] == '0);
			dfu_pkg::ACT_GET_IF: rsp_d.ack = !blk_nz;
			dfu_pkg::ACT_DOWNLOAD, dfu_pkg::ACT_GET_STATUS, dfu_pkg::ACT_GET_STATE,
			dfu_pkg::ACT_CLR_STATUS, dfu_pkg::ACT_ABORT: rsp_d.ack = 1'b1;
			default: rsp_d.ack = 1'b0;
		endcase
	end

	// Advance state when the held request moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			hw_q       <= '0;
			last_blk_q <= '0;
			state_q    <= dfu_pkg::ST_IDLE;
			status_q   <= dfu_pkg::STS_OK;
			target_q   <= 1'b0;
		end else if (fire) begin
			wp_q       <= wp_d;
			hw_q       <= hw_d;
			last_blk_q <= last_blk_d;
			state_q    <= state_d;
			status_q   <= status_d;
			target_q   <= target_d;
		end
	end

endmodule

// ----- hdl/dfu_out_stage.sv -----
module dfu_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid_s1,
	input  dfu_pkg::rsp_t rsp_d,
	output logic          fire,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dfu_pkg::rsp_t rsp
);

	// Move a result in when the register is empty or its beat leaves now
	assign fire = valid_s1 && (!rsp_valid || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else begin
			rsp_valid <= fire || (rsp_valid && rsp_stall);
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp <= rsp_d;
		end
	end

endmodule

// ----- hdl/dfu_checker.sv -----
`include "dfu_download_control_engine_top_macros.svh"

module dfu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input dfu_pkg::rsp_t rsp,
	input logic          cfg_valid,
	input logic          cfg_ready
);

	// Stalled result beat holds
	`DFU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, (rsp_valid && $stable(rsp)))

	// An accepted request is followed by a valid beat at the output, past the input and result registers
	`DFU_ASSERT_NEXT(a_latency, req_valid && !req_stall, ##1 rsp_valid)

	// Two beats fill the path while the output is stalled
	`DFU_ASSERT_NEXT(a_backpressure, rsp_valid && rsp_stall && req_valid && !req_stall,
		(!rsp_stall || req_stall))

	// Register writes are never held off
	`DFU_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind dfu_download_control_engine_top dfu_checker u_chk (.*);
